[rtl/core/ttc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttc_pkg - shared types and constants of the teletype text console
// Field widths, control codes, command kinds and the sequencer states used
// by the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package ttc_pkg;

   // field widths
   localparam int COL_FIELD_W  = 7;
   localparam int ROW_FIELD_W  = 5;
   localparam int CHAR_W       = 8;
   localparam int ATTR_W       = 8;
   localparam int CELL_W       = ATTR_W + CHAR_W;
   localparam int OP_W         = 2;
   localparam int REQ_TDATA_W  = 24;
   localparam int RSP_TDATA_W  = 32;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 8;
   localparam int QUEUE_DEPTH  = 2;

   // control characters
   localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;
   localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
   localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
   localparam logic [CHAR_W-1:0] CH_FF  = 8'd12;
   localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
   localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
   localparam int                TAB_STEP = 8;

   // reset values
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
   localparam logic [7:0]        COLS_RESET = 8'd80;
   localparam logic [5:0]        ROWS_RESET = 6'd25;

   typedef enum logic [OP_W-1:0] {
      OP_TELETYPE   = 2'd0,
      OP_WRITE_CELL = 2'd1,
      OP_READ_CELL  = 2'd2
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_COLUMNS  = 2'd0,
      CSR_ROWS     = 2'd1,
      CSR_CUR_ATTR = 2'd2,
      CSR_CLR_ATTR = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      CMD_PRINT  = 4'd0,
      CMD_CR     = 4'd1,
      CMD_LF     = 4'd2,
      CMD_TAB    = 4'd3,
      CMD_FF     = 4'd4,
      CMD_BS     = 4'd5,
      CMD_WRITE  = 4'd6,
      CMD_READ   = 4'd7,
      CMD_REJECT = 4'd8
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic [COL_FIELD_W-1:0]   column;
      logic [ROW_FIELD_W-1:0]   row;
      logic [CHAR_W-1:0]        char_code;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type entry;
   } q_push_type;

   typedef enum logic [2:0] {
      ST_INIT    = 3'd0,
      ST_IDLE    = 3'd1,
      ST_CHECK   = 3'd2,
      ST_ACCESS  = 3'd3,
      ST_RD_DATA = 3'd4,
      ST_SCROLL  = 3'd5,
      ST_FILL    = 3'd6,
      ST_RESULT  = 3'd7
   } bk_state_type;

endpackage
`default_nettype wire

[rtl/core/ttc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttc_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ttc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/core/ttc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttc_front - request front end
// Accepts items, decodes the operation and control characters into a
// command kind and range-checks cell positions before queueing.
// ----------------------------------------------------------------------------
module ttc_front #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_ROWS    = 32
) (
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [ttc_pkg::REQ_TDATA_W-1:0]     req_tdata,  // column, row, char_code
   input  wire logic [ttc_pkg::OP_W-1:0]            req_tuser,  // operation
   input  wire logic [$clog2(MAX_COLUMNS+1)-1:0]    cols_eff,
   input  wire logic [$clog2(MAX_ROWS+1)-1:0]       rows_eff,
   input  wire logic                                q_full,
   input  wire logic                                init_busy,
   output      ttc_pkg::q_push_type                 q_push
);

   localparam int CEW  = $clog2(MAX_COLUMNS + 1);
   localparam int REW  = $clog2(MAX_ROWS + 1);
   localparam int CMPC = CEW + ttc_pkg::COL_FIELD_W;
   localparam int CMPR = REW + ttc_pkg::ROW_FIELD_W;

   logic [ttc_pkg::COL_FIELD_W-1:0] column;
   logic [ttc_pkg::ROW_FIELD_W-1:0] row;
   logic [ttc_pkg::CHAR_W-1:0]      char_code;
   logic                            pos_ok;
   ttc_pkg::cmd_kind_type           kind;

   assign column    = req_tdata[6:0];
   assign row       = req_tdata[11:7];
   assign char_code = req_tdata[19:12];

   assign pos_ok = (CMPC'(column) < CMPC'(cols_eff)) && (CMPR'(row) < CMPR'(rows_eff));

   // classify the item
   always_comb begin
      kind = ttc_pkg::CMD_REJECT;
      unique case (ttc_pkg::op_type'(req_tuser))
         ttc_pkg::OP_TELETYPE: begin
            unique case (char_code)
               ttc_pkg::CH_CR:  kind = ttc_pkg::CMD_CR;
               ttc_pkg::CH_LF:  kind = ttc_pkg::CMD_LF;
               ttc_pkg::CH_TAB: kind = ttc_pkg::CMD_TAB;
               ttc_pkg::CH_FF:  kind = ttc_pkg::CMD_FF;
               ttc_pkg::CH_BS:  kind = ttc_pkg::CMD_BS;
               default:         kind = ttc_pkg::CMD_PRINT;
            endcase
         end
         ttc_pkg::OP_WRITE_CELL: kind = pos_ok ? ttc_pkg::CMD_WRITE : ttc_pkg::CMD_REJECT;
         ttc_pkg::OP_READ_CELL:  kind = pos_ok ? ttc_pkg::CMD_READ : ttc_pkg::CMD_REJECT;
         default:                kind = ttc_pkg::CMD_REJECT;
      endcase
   end

   // no items while the queue is full or the store is being cleared
   assign req_tready = !q_full && !init_busy;

   assign q_push.valid           = req_tvalid && req_tready;
   assign q_push.entry.kind      = kind;
   assign q_push.entry.column    = column;
   assign q_push.entry.row       = row;
   assign q_push.entry.char_code = char_code;

endmodule
`default_nettype wire

[rtl/core/ttc_cmd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttc_cmd_queue - command queue between front end and back end
// Short FIFO of decoded commands so each side can stall on its own.
// ----------------------------------------------------------------------------
module ttc_cmd_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ttc_pkg::q_push_type q_push,
   output      logic                q_full,
   input  wire logic                q_pop,
   output      logic                q_valid,
   output      ttc_pkg::cmd_type    q_head
);

   localparam int DEPTH = ttc_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);

   ttc_pkg::cmd_type slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign q_full  = (count_ff == (PW+1)'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_head  = slot_ff[rd_ptr_ff];

   assign do_push = q_push.valid && !q_full;
   assign do_pop  = q_pop && q_valid;

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

endmodule
`default_nettype wire

[rtl/core/ttc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttc_back - command back end
// Sequencer that owns the screen store and the cursor: prints, cell
// accesses, backspace read-modify-write, scroll copy, clear fill and the
// clearing pass after reset. Holds the result register.
// ----------------------------------------------------------------------------
module ttc_back #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_ROWS    = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_valid,
   input  wire ttc_pkg::cmd_type                  q_head,
   output      logic                              q_pop,
   input  wire logic [$clog2(MAX_COLUMNS+1)-1:0]  cols_eff,
   input  wire logic [$clog2(MAX_ROWS+1)-1:0]     rows_eff,
   input  wire logic [ttc_pkg::ATTR_W-1:0]        cur_attr,
   input  wire logic [ttc_pkg::ATTR_W-1:0]        clr_attr,
   output      logic                              init_busy,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [ttc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output      logic                              rsp_tuser
);

   localparam int CW    = $clog2(MAX_COLUMNS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
   localparam int IW    = $clog2(CELLS);
   localparam int TW    = IW + 1;
   localparam int CELL_W = ttc_pkg::CELL_W;

   ttc_pkg::bk_state_type state_ff, state_in;
   ttc_pkg::cmd_type      cmd_ff, cmd_in;
   logic [CW-1:0]         cur_col_ff, cur_col_in;
   logic [RW-1:0]         cur_row_ff, cur_row_in;
   logic [IW-1:0]         addr_ff, addr_in;
   logic [TW-1:0]         total_ff, total_in;
   logic [TW-1:0]         src_ff, src_in;
   logic [IW-1:0]         ptr_ff, ptr_in;
   logic                  pend_ff, pend_in;
   logic                  res_status_ff, res_status_in;
   logic [CELL_W-1:0]     res_cell_ff, res_cell_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ttc_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   // memory port
   logic                  wr_en, rd_en;
   logic [IW-1:0]         wr_addr, rd_addr;
   logic [CELL_W-1:0]     wr_data, rd_data;

   // cursor arithmetic
   logic                  cursor_on, last_row, col_wrap, tab_wrap, rd_go, fill_last;
   logic                  is_teletype, slot_free;
   logic [CW:0]           col_inc;
   logic [CW+3:0]         tab_sum;
   logic [CW-1:0]         col_last, bs_col, col_sel;
   logic [RW-1:0]         bs_row, row_sel;
   logic [TW-1:0]         addr_calc, total_calc;

   ttc_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cursor_on = ((CW+1)'(cur_col_ff) < (CW+1)'(cols_eff)) &&
                      ((RW+1)'(cur_row_ff) < (RW+1)'(rows_eff));
   assign last_row  = ((RW+1)'(cur_row_ff) + (RW+1)'(1)) >= (RW+1)'(rows_eff);
   assign col_inc   = (CW+1)'(cur_col_ff) + (CW+1)'(1);
   assign col_wrap  = col_inc >= (CW+1)'(cols_eff);
   assign tab_sum   = (CW+4)'(cur_col_ff) + (CW+4)'(ttc_pkg::TAB_STEP);
   assign tab_wrap  = tab_sum >= (CW+4)'(cols_eff);
   assign col_last  = CW'(cols_eff - 1'b1);

   // backspace target: at column 0 the last column of the row above (of row 0 itself on the top row)
   assign bs_col = (cur_col_ff == '0) ? col_last : cur_col_ff - CW'(1);
   assign bs_row = ((cur_col_ff == '0) && (cur_row_ff != '0)) ? cur_row_ff - RW'(1)
                                                             : cur_row_ff;

   assign is_teletype = (cmd_ff.kind != ttc_pkg::CMD_WRITE) &&
                        (cmd_ff.kind != ttc_pkg::CMD_READ) &&
                        (cmd_ff.kind != ttc_pkg::CMD_REJECT);

   // cell address: explicit position, backspace target or cursor
   always_comb begin
      col_sel = cur_col_ff;
      row_sel = cur_row_ff;
      if ((cmd_ff.kind == ttc_pkg::CMD_WRITE) || (cmd_ff.kind == ttc_pkg::CMD_READ)) begin
         col_sel = CW'(cmd_ff.column);
         row_sel = RW'(cmd_ff.row);
      end else if (cmd_ff.kind == ttc_pkg::CMD_BS) begin
         col_sel = bs_col;
         row_sel = bs_row;
      end
   end

   assign addr_calc  = TW'(row_sel) * TW'(cols_eff) + TW'(col_sel);
   assign total_calc = TW'(rows_eff) * TW'(cols_eff);
   assign rd_go      = src_ff < total_ff;
   assign fill_last  = ((TW'(ptr_ff) + TW'(1)) == total_ff);
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ttc_pkg::ST_INIT: begin
            if (ptr_ff == IW'(CELLS - 1)) begin
               state_in = ttc_pkg::ST_IDLE;
            end
         end
         ttc_pkg::ST_IDLE: begin
            if (q_valid) begin
               state_in = ttc_pkg::ST_CHECK;
            end
         end
         ttc_pkg::ST_CHECK: begin
            if (is_teletype && !cursor_on) begin
               state_in = ttc_pkg::ST_RESULT;
            end else begin
               unique case (cmd_ff.kind)
                  ttc_pkg::CMD_WRITE, ttc_pkg::CMD_READ,
                  ttc_pkg::CMD_PRINT, ttc_pkg::CMD_BS: state_in = ttc_pkg::ST_ACCESS;
                  ttc_pkg::CMD_LF:
                     state_in = last_row ? ttc_pkg::ST_SCROLL : ttc_pkg::ST_RESULT;
                  ttc_pkg::CMD_TAB:
                     state_in = (tab_wrap && last_row) ? ttc_pkg::ST_SCROLL
                                                       : ttc_pkg::ST_RESULT;
                  ttc_pkg::CMD_FF: state_in = ttc_pkg::ST_FILL;
                  default:         state_in = ttc_pkg::ST_RESULT;
               endcase
            end
         end
         ttc_pkg::ST_ACCESS: begin
            unique case (cmd_ff.kind)
               ttc_pkg::CMD_PRINT:
                  state_in = (col_wrap && last_row) ? ttc_pkg::ST_SCROLL : ttc_pkg::ST_RESULT;
               ttc_pkg::CMD_READ, ttc_pkg::CMD_BS: state_in = ttc_pkg::ST_RD_DATA;
               default: state_in = ttc_pkg::ST_RESULT;
            endcase
         end
         ttc_pkg::ST_RD_DATA: state_in = ttc_pkg::ST_RESULT;
         ttc_pkg::ST_SCROLL: begin
            if (!rd_go && !pend_ff) begin
               state_in = ttc_pkg::ST_FILL;
            end
         end
         ttc_pkg::ST_FILL: begin
            if (fill_last) begin
               state_in = ttc_pkg::ST_RESULT;
            end
         end
         ttc_pkg::ST_RESULT: begin
            if (slot_free) begin
               state_in = ttc_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // datapath, memory controls and result
   always_comb begin
      cmd_in        = cmd_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      addr_in       = addr_ff;
      total_in      = total_ff;
      src_in        = src_ff;
      ptr_in        = ptr_ff;
      pend_in       = pend_ff;
      res_status_in = res_status_ff;
      res_cell_in   = res_cell_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = {cur_attr, cmd_ff.char_code};
      rd_en         = 1'b0;
      rd_addr       = addr_ff;

      unique case (state_ff)
         // reset clearing pass over the whole store
         ttc_pkg::ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = {ttc_pkg::RESET_ATTR, ttc_pkg::CH_NUL};
            ptr_in  = ptr_ff + IW'(1);
         end
         ttc_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
            end
         end
         ttc_pkg::ST_CHECK: begin
            addr_in       = IW'(addr_calc);
            total_in      = total_calc;
            src_in        = TW'(cols_eff);
            ptr_in        = '0;
            pend_in       = 1'b0;
            res_status_in = 1'b0;
            res_cell_in   = '0;
            if ((cmd_ff.kind == ttc_pkg::CMD_REJECT) || (is_teletype && !cursor_on)) begin
               res_status_in = 1'b1;
            end else begin
               unique case (cmd_ff.kind)
                  ttc_pkg::CMD_CR: cur_col_in = '0;
                  ttc_pkg::CMD_LF: begin
                     if (!last_row) begin
                        cur_row_in = cur_row_ff + RW'(1);
                     end
                  end
                  ttc_pkg::CMD_TAB: begin
                     if (tab_wrap) begin
                        cur_col_in = '0;
                        if (!last_row) begin
                           cur_row_in = cur_row_ff + RW'(1);
                        end
                     end else begin
                        cur_col_in = CW'(tab_sum);
                     end
                  end
                  ttc_pkg::CMD_BS: begin
                     cur_col_in = bs_col;
                     cur_row_in = bs_row;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ttc_pkg::ST_ACCESS: begin
            unique case (cmd_ff.kind)
               ttc_pkg::CMD_WRITE: wr_en = 1'b1;
               ttc_pkg::CMD_PRINT: begin
                  wr_en = 1'b1;
                  if (col_wrap) begin
                     cur_col_in = '0;
                     if (!last_row) begin
                        cur_row_in = cur_row_ff + RW'(1);
                     end
                  end else begin
                     cur_col_in = CW'(col_inc);
                  end
               end
               ttc_pkg::CMD_READ, ttc_pkg::CMD_BS: rd_en = 1'b1;
               default: begin
               end
            endcase
         end
         ttc_pkg::ST_RD_DATA: begin
            if (cmd_ff.kind == ttc_pkg::CMD_READ) begin
               res_cell_in = rd_data;
            end else begin
               // backspace blanks the character, keeps the attribute
               wr_en   = 1'b1;
               wr_data = {rd_data[CELL_W-1:ttc_pkg::CHAR_W], ttc_pkg::CH_NUL};
            end
         end
         // copy each cell up one row: read i+cols, write i in the next cycle
         ttc_pkg::ST_SCROLL: begin
            rd_en   = rd_go;
            rd_addr = IW'(src_ff);
            pend_in = rd_go;
            if (rd_go) begin
               src_in = src_ff + TW'(1);
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = ptr_ff;
               wr_data = rd_data;
               ptr_in  = ptr_ff + IW'(1);
            end
         end
         // fill from ptr up to the end of the screen area
         ttc_pkg::ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = {clr_attr, ttc_pkg::CH_NUL};
            ptr_in  = ptr_ff + IW'(1);
         end
         ttc_pkg::ST_RESULT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_status_ff;
               rsp_data_in  = {4'b0000, res_cell_ff,
                               ttc_pkg::ROW_FIELD_W'(cur_row_ff),
                               ttc_pkg::COL_FIELD_W'(cur_col_ff)};
            end
         end
      endcase
   end

   assign init_busy  = (state_ff == ttc_pkg::ST_INIT);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttc_pkg::ST_INIT;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      total_ff      <= total_in;
      src_ff        <= src_in;
      res_status_ff <= res_status_in;
      res_cell_ff   <= res_cell_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

endmodule
`default_nettype wire

[rtl/core/teletype_text_console_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// teletype_text_console_core - text-mode teletype console
// Screen store of attribute/character cells with a cursor; teletype
// printing with control characters, scroll and clear, cell write and read.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_tvalid/req_tready  | tdata: column, row, char_code
//          |           |                        | tuser: operation
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata: cursor col/row, cell char/attr
//          |           |                        | tuser: status
//  csr     | in        | csr_we                 | csr_addr, csr_wdata
//
//  Each item passes the check and result states of the back-end sequencer;
//  a print, cell access or backspace adds an access state, and a read or
//  backspace a read-data state too, as they read the store first. Line feed
//  or wrap on the last row adds a scroll; form feed clears the screen.
//  After reset a clearing pass over all MAX_COLUMNS*MAX_ROWS cells (4096 by
//  default) runs with req_tready low. The queue and result register let the
//  request side keep going while a result waits.
// ----------------------------------------------------------------------------
module teletype_text_console_core #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_ROWS    = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [ttc_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [6:0] column, [11:7] row,
                                                              // [19:12] char_code
   input  wire logic [ttc_pkg::OP_W-1:0]          req_tuser,  // [1:0] operation
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [ttc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // [6:0] cursor_column_out,
                                                              // [11:7] cursor_row_out,
                                                              // [19:12] cell_char,
                                                              // [27:20] cell_attribute
   output      logic                              rsp_tuser,  // [0] status
   input  wire logic                              csr_we,
   input  wire logic [ttc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [ttc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CEW  = $clog2(MAX_COLUMNS + 1);
   localparam int REW  = $clog2(MAX_ROWS + 1);
   localparam int CMPC = CEW + 8;
   localparam int CMPR = REW + 6;

   logic [7:0]                   columns_ff;
   logic [5:0]                   rows_ff;
   logic [ttc_pkg::ATTR_W-1:0]   cur_attr_ff;
   logic [ttc_pkg::ATTR_W-1:0]   clr_attr_ff;
   logic [CEW-1:0]               cols_eff;
   logic [REW-1:0]               rows_eff;
   logic                         init_busy;
   logic                         q_full, q_valid, q_pop;
   ttc_pkg::q_push_type          q_push;
   ttc_pkg::cmd_type             q_head;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff  <= ttc_pkg::COLS_RESET;
         rows_ff     <= ttc_pkg::ROWS_RESET;
         cur_attr_ff <= ttc_pkg::RESET_ATTR;
         clr_attr_ff <= ttc_pkg::RESET_ATTR;
      end else if (csr_we) begin
         unique case (ttc_pkg::csr_index_type'(csr_addr))
            ttc_pkg::CSR_COLUMNS:  columns_ff  <= csr_wdata;
            ttc_pkg::CSR_ROWS:     rows_ff     <= csr_wdata[5:0];
            ttc_pkg::CSR_CUR_ATTR: cur_attr_ff <= csr_wdata;
            ttc_pkg::CSR_CLR_ATTR: clr_attr_ff <= csr_wdata;
         endcase
      end
   end

   // screen size saturated to 1..MAX
   always_comb begin
      if (columns_ff == '0) begin
         cols_eff = CEW'(1);
      end else if (CMPC'(columns_ff) > CMPC'(MAX_COLUMNS)) begin
         cols_eff = CEW'(MAX_COLUMNS);
      end else begin
         cols_eff = CEW'(columns_ff);
      end
      if (rows_ff == '0) begin
         rows_eff = REW'(1);
      end else if (CMPR'(rows_ff) > CMPR'(MAX_ROWS)) begin
         rows_eff = REW'(MAX_ROWS);
      end else begin
         rows_eff = REW'(rows_ff);
      end
   end

   ttc_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cols_eff   (cols_eff),
      .rows_eff   (rows_eff),
      .q_full     (q_full),
      .init_busy  (init_busy),
      .q_push     (q_push)
   );

   ttc_cmd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_valid (q_valid),
      .q_head  (q_head)
   );

   ttc_back #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .cols_eff   (cols_eff),
      .rows_eff   (rows_eff),
      .cur_attr   (cur_attr_ff),
      .clr_attr   (clr_attr_ff),
      .init_busy  (init_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   // no result can come out while the store is still being cleared
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> !rsp_tvalid)
      else $error("result valid during clearing pass");

   // the clearing pass runs once after reset
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      !init_busy |=> !init_busy)
      else $error("clearing pass restarted");

   // nothing reaches the queue before the store is ready
   a_queue_empty_in_clear: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> !q_valid)
      else $error("command queued during clearing pass");
`endif

endmodule
`default_nettype wire
